// ----- sv/qrs_pkg.sv -----
package qrs_pkg;

  // Solution class reported with every result
  typedef enum logic [1:0] {
    CASE_NONE    = 2'd0,  // a and b both zero
    CASE_SINGLE  = 2'd1,  // linear equation, root -c/b
    CASE_COMPLEX = 2'd2,  // negative discriminant
    CASE_TWO     = 2'd3   // two real roots
  } case_t;

endpackage

// ----- sv/qrs_sqrt_cell.sv -----
// One digit of the digit-by-digit square root: brings down two radicand bits,
// tries root*4+1 against the partial remainder, appends one root bit.
module qrs_sqrt_cell #(
  parameter int DIGITS = 33
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [DIGITS+1:0]     rem_i,
  input  logic [DIGITS-1:0]     root_i,
  input  logic [2*DIGITS-1:0]   rad_i,
  output logic [DIGITS+1:0]     rem_o,
  output logic [DIGITS-1:0]     root_o,
  output logic [2*DIGITS-1:0]   rad_o
);

  logic [DIGITS+1:0] rem2;
  logic [DIGITS+1:0] trial;
  logic [DIGITS+1:0] diff;
  logic              ge;

  // trial subtraction; the remainder never exceeds DIGITS bits before the shift
  always_comb begin
    rem2  = {rem_i[DIGITS-1:0], rad_i[2*DIGITS-1 -: 2]};
    trial = {root_i, 2'b01};
    ge    = (rem2 >= trial);
    diff  = rem2 - trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= ge ? diff : rem2;
      root_o <= {root_i[DIGITS-2:0], ge};
      rad_o  <= rad_i << 2;
    end
  end

endmodule

// ----- sv/qrs_div_cell.sv -----
// One step of restoring division on magnitudes: numerator bits shift out at
// the top of nq while quotient bits shift in at the bottom.
module qrs_div_cell #(
  parameter int NUM_BITS = 34,
  parameter int DEN_BITS = 17
) (
  input  logic                clk,
  input  logic                en,
  input  logic [DEN_BITS-1:0] den_i,
  input  logic [DEN_BITS-1:0] rem_i,
  input  logic [NUM_BITS-1:0] nq_i,
  output logic [DEN_BITS-1:0] den_o,
  output logic [DEN_BITS-1:0] rem_o,
  output logic [NUM_BITS-1:0] nq_o
);

  logic [DEN_BITS:0] r2;
  logic [DEN_BITS:0] diff;
  logic              ge;

  always_comb begin
    r2   = {rem_i, nq_i[NUM_BITS-1]};
    ge   = (r2 >= {1'b0, den_i});
    diff = r2 - {1'b0, den_i};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_o <= den_i;
      rem_o <= ge ? diff[DEN_BITS-1:0] : r2[DEN_BITS-1:0];
      nq_o  <= {nq_i[NUM_BITS-2:0], ge};
    end
  end

endmodule

// ----- sv/quadratic_real_root_solver_top.sv -----
// Real roots of a*x^2 + b*x + c = 0.
// Input stream (s_*): one transfer carries coefficients a, b, c as signed
// integers. Output stream (m_*): one transfer per input with a case code and
// two signed Q fixed-point roots, truncated toward zero; unused roots are zero.
// Datapath: input register, product stage, discriminant stage, a chain of
// COEF_BITS+FRAC_BITS+1 square-root cells (one root bit each), a numerator
// stage, two parallel chains of COEF_BITS+FRAC_BITS+2 division cells (one
// quotient bit each), then the output register.
// Depth: 2*COEF_BITS + 2*FRAC_BITS + 8 register stages, from the input
// register to the output register. Throughput: one item per cycle while the
// skid register is empty; the depth of the digit chains sets the latency,
// and every cell takes a new item each cycle unless the pipeline holds.
// Stall: a skid register behind the output register catches one item when
// m_tready drops; while it is full the whole pipeline holds and s_tready is
// low. s_tready comes from a register, not from m_tready.
// Reset (rst, synchronous) empties the pipeline and both output registers.
module quadratic_real_root_solver_top
  import qrs_pkg::*;
#(
  parameter int COEF_BITS = 16,
  parameter int FRAC_BITS = 16,
  localparam int IW = ((3 * COEF_BITS + 7) / 8) * 8,
  localparam int RB = COEF_BITS + FRAC_BITS + 3,
  localparam int OW = ((2 + 2 * RB + 7) / 8) * 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [IW-1:0] s_tdata,   // coef_quad, coef_lin, coef_const, zero fill
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [OW-1:0] m_tdata    // case_code, root_plus, root_minus, zero fill
);

  localparam int N  = COEF_BITS;
  localparam int F  = FRAC_BITS;
  localparam int SQ = N + 1 + F;     // root digits
  localparam int RW = 2 * SQ;        // radicand width
  localparam int NW = N + F + 2;     // numerator magnitude / quotient width
  localparam int DW = N + 1;         // divisor magnitude width
  localparam int DL = 2 * N + 2;     // discriminant width

  typedef struct packed {
    logic                v;
    case_t               code;
    logic signed [N-1:0] a;
    logic signed [N-1:0] b;
    logic signed [N-1:0] c;
  } sq_side_t;

  typedef struct packed {
    logic  v;
    case_t code;
    logic  neg_a;
    logic  neg_b;
  } dv_side_t;

  logic en;

  // input register
  logic                v1;
  logic signed [N-1:0] a1, b1, c1;

  // product stage
  logic                  v2;
  logic signed [2*N-1:0] bb2, ac2;
  logic signed [N-1:0]   a2, b2, c2;

  // discriminant stage
  logic signed [DL-1:0] d_next;
  case_t                code_next;
  sq_side_t             sq_side [0:SQ];
  logic [DL-1:0]        d3;

  // square-root chain
  logic [SQ+1:0]  sq_rem  [0:SQ];
  logic [SQ-1:0]  sq_root [0:SQ];
  logic [RW-1:0]  sq_rad  [0:SQ];

  // numerator stage
  logic signed [NW:0]   nb_w, s_w, c_w, num_a, num_b;
  logic signed [DW+1:0] den_w;
  logic [NW:0]          mag_a, mag_b;
  logic [DW+1:0]        mag_d;
  dv_side_t             dv_side [0:NW];

  // division chains
  logic [DW-1:0] da_den [0:NW];
  logic [DW-1:0] da_rem [0:NW];
  logic [NW-1:0] da_nq  [0:NW];
  logic [DW-1:0] db_den [0:NW];
  logic [DW-1:0] db_rem [0:NW];
  logic [NW-1:0] db_nq  [0:NW];

  // output side
  logic          pend_v;
  logic [RB-1:0] rp_next, rm_next;
  logic          skid_v;
  case_t         skid_code, out_code;
  logic [RB-1:0] skid_rp, skid_rm, out_rp, out_rm;

  assign en       = !skid_v;
  assign s_tready = en;

  // input register and products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1  <= s_tdata[N-1:0];
      b1  <= s_tdata[2*N-1:N];
      c1  <= s_tdata[3*N-1:2*N];
      bb2 <= b1 * b1;
      ac2 <= a1 * c1;
      a2  <= a1;
      b2  <= b1;
      c2  <= c1;
    end
  end

  // discriminant and case decision
  always_comb begin
    d_next = DL'(bb2) - (DL'(ac2) <<< 2);
    if (a2 == '0 && b2 == '0) begin
      code_next = CASE_NONE;
    end else if (a2 == '0) begin
      code_next = CASE_SINGLE;
    end else if (d_next < 0) begin
      code_next = CASE_COMPLEX;
    end else begin
      code_next = CASE_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_side[0].v <= 1'b0;
    end else if (en) begin
      sq_side[0].v <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side[0].code <= code_next;
      sq_side[0].a    <= a2;
      sq_side[0].b    <= b2;
      sq_side[0].c    <= c2;
      d3              <= d_next;
    end
  end

  // radicand is d scaled by 2^(2F); zero unless two roots
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = (sq_side[0].code == CASE_TWO) ? (RW'(d3[2*N:0]) << (2 * F)) : '0;

  // square-root chain with its side band
  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    qrs_sqrt_cell #(.DIGITS(SQ)) u_cell (
      .clk    (clk),
      .en     (en),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .rad_i  (sq_rad[k]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .rad_o  (sq_rad[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_side[k+1].v <= 1'b0;
      end else if (en) begin
        sq_side[k+1].v <= sq_side[k].v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_side[k+1].code <= sq_side[k].code;
        sq_side[k+1].a    <= sq_side[k].a;
        sq_side[k+1].b    <= sq_side[k].b;
        sq_side[k+1].c    <= sq_side[k].c;
      end
    end
  end

  // numerators and divisor, split into magnitude and sign
  always_comb begin
    nb_w  = -((NW+1)'(sq_side[SQ].b) <<< F);
    c_w   = -((NW+1)'(sq_side[SQ].c) <<< F);
    s_w   = signed'((NW+1)'(sq_root[SQ]));
    num_a = '0;
    num_b = '0;
    den_w = (DW+2)'(1);
    unique case (sq_side[SQ].code)
      CASE_TWO: begin
        num_a = nb_w + s_w;
        num_b = nb_w - s_w;
        den_w = (DW+2)'(sq_side[SQ].a) <<< 1;
      end
      CASE_SINGLE: begin
        num_a = c_w;
        den_w = (DW+2)'(sq_side[SQ].b);
      end
      default: begin
        num_a = '0;
      end
    endcase
    mag_a = num_a[NW] ? -num_a : num_a;
    mag_b = num_b[NW] ? -num_b : num_b;
    mag_d = den_w[DW+1] ? -den_w : den_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_side[0].v <= 1'b0;
    end else if (en) begin
      dv_side[0].v <= sq_side[SQ].v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side[0].code  <= sq_side[SQ].code;
      dv_side[0].neg_a <= num_a[NW] ^ den_w[DW+1];
      dv_side[0].neg_b <= num_b[NW] ^ den_w[DW+1];
      da_nq[0]         <= mag_a[NW-1:0];
      db_nq[0]         <= mag_b[NW-1:0];
      da_den[0]        <= mag_d[DW-1:0];
      db_den[0]        <= mag_d[DW-1:0];
    end
  end

  assign da_rem[0] = '0;
  assign db_rem[0] = '0;

  // division chains, one per root
  for (genvar k = 0; k < NW; k++) begin : g_div
    qrs_div_cell #(.NUM_BITS(NW), .DEN_BITS(DW)) u_lane_a (
      .clk   (clk),
      .en    (en),
      .den_i (da_den[k]),
      .rem_i (da_rem[k]),
      .nq_i  (da_nq[k]),
      .den_o (da_den[k+1]),
      .rem_o (da_rem[k+1]),
      .nq_o  (da_nq[k+1])
    );

    qrs_div_cell #(.NUM_BITS(NW), .DEN_BITS(DW)) u_lane_b (
      .clk   (clk),
      .en    (en),
      .den_i (db_den[k]),
      .rem_i (db_rem[k]),
      .nq_i  (db_nq[k]),
      .den_o (db_den[k+1]),
      .rem_o (db_rem[k+1]),
      .nq_o  (db_nq[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_side[k+1].v <= 1'b0;
      end else if (en) begin
        dv_side[k+1].v <= dv_side[k].v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_side[k+1].code  <= dv_side[k].code;
        dv_side[k+1].neg_a <= dv_side[k].neg_a;
        dv_side[k+1].neg_b <= dv_side[k].neg_b;
      end
    end
  end

  // sign fix and zeroing of unused roots
  always_comb begin
    rp_next = '0;
    rm_next = '0;
    if (dv_side[NW].code == CASE_TWO || dv_side[NW].code == CASE_SINGLE) begin
      rp_next = dv_side[NW].neg_a ? -RB'(da_nq[NW]) : RB'(da_nq[NW]);
    end
    if (dv_side[NW].code == CASE_TWO) begin
      rm_next = dv_side[NW].neg_b ? -RB'(db_nq[NW]) : RB'(db_nq[NW]);
    end
  end

  assign pend_v = en && dv_side[NW].v;

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= skid_v || pend_v;
      skid_v   <= 1'b0;
    end else if (pend_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      out_code <= skid_v ? skid_code : dv_side[NW].code;
      out_rp   <= skid_v ? skid_rp : rp_next;
      out_rm   <= skid_v ? skid_rm : rm_next;
    end else if (pend_v) begin
      skid_code <= dv_side[NW].code;
      skid_rp   <= rp_next;
      skid_rm   <= rm_next;
    end
  end

  assign m_tdata = OW'({out_rm, out_rp, out_code});

  // the skid register only fills behind a stalled output
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(m_tvalid && !m_tready))
    else $error("skid filled without output stall");

  // roots without meaning are zero
  a_zero_roots: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_code == CASE_NONE || out_code == CASE_COMPLEX)
      |-> (out_rp == '0 && out_rm == '0))
    else $error("nonzero root for a case without roots");

  // square-root remainder bound at the end of the chain
  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    sq_side[SQ].v |-> (sq_rem[SQ] <= {1'b0, sq_root[SQ], 1'b0}))
    else $error("square-root remainder out of range");

  // division remainders below the divisor
  a_div_rem_a: assert property (@(posedge clk) disable iff (rst)
    dv_side[NW].v |-> (da_rem[NW] < da_den[NW]))
    else $error("lane a remainder not below divisor");

  a_div_rem_b: assert property (@(posedge clk) disable iff (rst)
    dv_side[NW].v |-> (db_rem[NW] < db_den[NW]))
    else $error("lane b remainder not below divisor");

endmodule
